[rtl/isb_pkg.sv]
`timescale 1ns / 1ps

package isb_pkg;

   // field widths
   localparam int OP_W      = 4;
   localparam int REG_W     = 4;
   localparam int LIMB_W    = 9;
   localparam int CFG_W     = 8;
   localparam int CFG_IDX_W = 3;
   localparam int CNT_W     = 24;

   // defaults for the top level parameters
   localparam int NUM_REGS_DEF   = 16;
   localparam int CTRL_DELAY_DEF = 1;
   localparam int MAX_LIMBS_DEF  = 256;

   typedef logic [CNT_W-1:0] cnt_type;
   localparam cnt_type CNT_MAX = '1;

   // opcodes
   localparam logic [OP_W-1:0] OP_LOAD_A  = 4'd1;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 4'd2;
   localparam logic [OP_W-1:0] OP_LOAD_AB = 4'd3;
   localparam logic [OP_W-1:0] OP_UNLOAD  = 4'd4;
   localparam logic [OP_W-1:0] OP_MULT    = 4'd8;
   localparam logic [OP_W-1:0] OP_ADD     = 4'd9;
   localparam logic [OP_W-1:0] OP_SUB     = 4'd10;

   // control register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_LD_SETUP  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_LD_HOLD   = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_UL_SETUP  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_UL_HOLD   = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_MUL_SETUP = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_MUL_DRAIN = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_AS_SETUP  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_AS_DRAIN  = 3'd7;

   // shared resource counters
   localparam int U_ROUTE0     = 0;
   localparam int U_ROUTE1     = 1;
   localparam int U_DMA_ADDSUB = 2;
   localparam int U_DMA_MULT   = 3;
   localparam int U_DMA_UNLOAD = 4;
   localparam int U_ADDER      = 5;
   localparam int U_MULT       = 6;
   localparam int U_PORT_A     = 7;
   localparam int U_PORT_B     = 8;
   localparam int NUM_UNITS    = 9;

   typedef struct packed {
      logic [OP_W-1:0]   op_code;
      logic [REG_W-1:0]  first_reg;
      logic [LIMB_W-1:0] first_limbs;
      logic [REG_W-1:0]  second_reg;
      logic [LIMB_W-1:0] second_limbs;
      logic [REG_W-1:0]  dest_reg;
   } isb_cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] ld_setup;
      logic [CFG_W-1:0] ld_hold;
      logic [CFG_W-1:0] ul_setup;
      logic [CFG_W-1:0] ul_hold;
      logic [CFG_W-1:0] mul_setup;
      logic [CFG_W-1:0] mul_drain;
      logic [CFG_W-1:0] as_setup;
      logic [CFG_W-1:0] as_drain;
   } isb_cfg_type;

   function automatic cnt_type cnt_sat_add(input cnt_type a, input cnt_type b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic cnt_type cnt_drop(input cnt_type x, input cnt_type t);
      return (x > t) ? (x - t) : '0;
   endfunction

   function automatic cnt_type cnt_max(input cnt_type a, input cnt_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

[rtl/isb_update.sv]
`timescale 1ns / 1ps

module isb_update #(
   parameter int NUM_REGS   = isb_pkg::NUM_REGS_DEF,
   parameter int CTRL_DELAY = isb_pkg::CTRL_DELAY_DEF,
   parameter int MAX_LIMBS  = isb_pkg::MAX_LIMBS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 cmd_valid,
   input  isb_pkg::isb_cmd_type cmd,
   input  isb_pkg::isb_cfg_type cfg,
   output isb_pkg::cnt_type     stall_cycles,
   output isb_pkg::cnt_type     reg_busy [NUM_REGS],
   output isb_pkg::cnt_type     unit_busy [isb_pkg::NUM_UNITS]
);
   import isb_pkg::*;

   localparam int LCMP_W = 11;
   localparam logic [LCMP_W-1:0] MAX_LIMBS_V = LCMP_W'(MAX_LIMBS);

   cnt_type reg_ff [NUM_REGS];
   cnt_type reg_in [NUM_REGS];
   cnt_type unit_ff [NUM_UNITS];
   cnt_type unit_in [NUM_UNITS];
   cnt_type stall_ff;
   cnt_type stall_in;

   logic [LIMB_W-1:0]   la, lb, lmax;
   logic [2*LIMB_W-1:0] prod;
   cnt_type load_a, load_b, unload_part, op_part, op_full;
   cnt_type rd_a, rd_b, rd_c, rmin, wait_cnt;
   cnt_type val_a, val_b, val_c, e_route;
   cnt_type e_unit [NUM_UNITS];
   logic    en_a, en_b, en_c;
   logic    is_mult;
   logic [CFG_W-1:0] op_pre, op_post;
   cnt_type r0_drop, r1_drop;

   // limb clamp and per-op busy times
   always_comb begin
      la = ({2'b00, cmd.first_limbs} > MAX_LIMBS_V) ? LIMB_W'(MAX_LIMBS) : cmd.first_limbs;
      lb = ({2'b00, cmd.second_limbs} > MAX_LIMBS_V) ? LIMB_W'(MAX_LIMBS) : cmd.second_limbs;
      lmax = (la > lb) ? la : lb;
      prod = (2*LIMB_W)'(la) * (2*LIMB_W)'(lb);
      is_mult = (cmd.op_code == OP_MULT);
      op_pre  = is_mult ? cfg.mul_setup : cfg.as_setup;
      op_post = is_mult ? cfg.mul_drain : cfg.as_drain;
      load_a = CNT_W'(cfg.ld_setup) + CNT_W'(la);
      load_b = CNT_W'(cfg.ld_setup) + CNT_W'(lb);
      unload_part = CNT_W'(cfg.ul_setup) + CNT_W'(la);
      op_part = CNT_W'(op_pre) + (is_mult ? CNT_W'(prod) : CNT_W'(lmax));
      op_full = op_part + CNT_W'(op_post);
   end

   // register counter reads, out of range indexes read as idle
   always_comb begin
      rd_a = '0;
      rd_b = '0;
      rd_c = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (32'(cmd.first_reg) == 32'(i))  rd_a = rd_a | reg_ff[i];
         if (32'(cmd.second_reg) == 32'(i)) rd_b = rd_b | reg_ff[i];
         if (32'(cmd.dest_reg) == 32'(i))   rd_c = rd_c | reg_ff[i];
      end
      rmin = (unit_ff[U_ROUTE0] < unit_ff[U_ROUTE1]) ? unit_ff[U_ROUTE0] : unit_ff[U_ROUTE1];
   end

   always_comb begin
      wait_cnt = '0;
      en_a = 1'b0;
      en_b = 1'b0;
      en_c = 1'b0;
      val_a = '0;
      val_b = '0;
      val_c = '0;
      e_route = '0;
      for (int u = 0; u < NUM_UNITS; u++) e_unit[u] = '0;
      case (cmd.op_code)
         OP_LOAD_A: begin
            wait_cnt = cnt_max(rd_a, unit_ff[U_PORT_A]);
            en_a = 1'b1;
            val_a = load_a;
            e_unit[U_PORT_A] = load_a;
         end
         OP_LOAD_B: begin
            wait_cnt = cnt_max(rd_b, unit_ff[U_PORT_B]);
            en_b = 1'b1;
            val_b = load_b;
            e_unit[U_PORT_B] = load_b;
         end
         OP_LOAD_AB: begin
            wait_cnt = cnt_max(cnt_max(rd_a, rd_b), cnt_max(unit_ff[U_PORT_A], unit_ff[U_PORT_B]));
            en_a = 1'b1;
            en_b = 1'b1;
            val_a = load_a + CNT_W'(cfg.ld_hold);
            val_b = load_b + CNT_W'(cfg.ld_hold);
            e_unit[U_PORT_A] = load_a;
            e_unit[U_PORT_B] = load_b;
         end
         OP_UNLOAD: begin
            wait_cnt = cnt_max(cnt_max(unit_ff[U_DMA_UNLOAD], rmin), rd_a);
            en_a = 1'b1;
            val_a = unload_part;
            e_route = unload_part;
            e_unit[U_DMA_UNLOAD] = unload_part + CNT_W'(cfg.ul_hold);
         end
         OP_MULT: begin
            wait_cnt = cnt_max(cnt_max(cnt_max(rd_a, rd_b), cnt_max(rd_c, rmin)),
                               cnt_max(unit_ff[U_DMA_MULT], unit_ff[U_MULT]));
            en_a = 1'b1;
            en_b = 1'b1;
            en_c = 1'b1;
            val_a = op_part;
            val_b = op_part;
            val_c = op_full;
            e_route = op_full;
            e_unit[U_DMA_MULT] = op_full;
            e_unit[U_MULT] = op_full;
         end
         OP_ADD, OP_SUB: begin
            wait_cnt = cnt_max(cnt_max(cnt_max(rd_a, rd_b), cnt_max(rd_c, rmin)),
                               cnt_max(unit_ff[U_DMA_ADDSUB], unit_ff[U_ADDER]));
            en_a = 1'b1;
            en_b = 1'b1;
            en_c = 1'b1;
            val_a = op_part;
            val_b = op_part;
            val_c = op_full;
            e_route = op_full;
            e_unit[U_DMA_ADDSUB] = op_full;
            e_unit[U_ADDER] = op_full;
         end
         default: begin
            wait_cnt = '0;
         end
      endcase
      stall_in = cnt_sat_add(CNT_W'(CTRL_DELAY), wait_cnt);
   end

   // drop every counter by the stall, then add the new busy times
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (en_c && (32'(cmd.dest_reg) == 32'(i))) begin
            reg_in[i] = cnt_sat_add(cnt_drop(reg_ff[i], stall_in), val_c);
         end else if (en_b && (32'(cmd.second_reg) == 32'(i))) begin
            reg_in[i] = cnt_sat_add(cnt_drop(reg_ff[i], stall_in), val_b);
         end else if (en_a && (32'(cmd.first_reg) == 32'(i))) begin
            reg_in[i] = cnt_sat_add(cnt_drop(reg_ff[i], stall_in), val_a);
         end else begin
            reg_in[i] = cnt_drop(reg_ff[i], stall_in);
         end
      end
      for (int u = 0; u < NUM_UNITS; u++) begin
         unit_in[u] = cnt_sat_add(cnt_drop(unit_ff[u], stall_in), e_unit[u]);
      end
      // route zero takes the new time when it has drained
      r0_drop = cnt_drop(unit_ff[U_ROUTE0], stall_in);
      r1_drop = cnt_drop(unit_ff[U_ROUTE1], stall_in);
      if (r0_drop == '0) begin
         unit_in[U_ROUTE0] = e_route;
         unit_in[U_ROUTE1] = r1_drop;
      end else begin
         unit_in[U_ROUTE0] = r0_drop;
         unit_in[U_ROUTE1] = cnt_sat_add(r1_drop, e_route);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) reg_ff[i] <= '0;
         for (int u = 0; u < NUM_UNITS; u++) unit_ff[u] <= '0;
      end else if (advance && cmd_valid) begin
         reg_ff <= reg_in;
         unit_ff <= unit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stall_ff <= stall_in;
      end
   end

   assign stall_cycles = stall_ff;
   assign reg_busy = reg_ff;
   assign unit_busy = unit_ff;

endmodule

[rtl/isb_drain.sv]
`timescale 1ns / 1ps

module isb_drain #(
   parameter int NUM_REGS = isb_pkg::NUM_REGS_DEF
) (
   input  isb_pkg::cnt_type reg_busy [NUM_REGS],
   input  isb_pkg::cnt_type unit_busy [isb_pkg::NUM_UNITS],
   output isb_pkg::cnt_type drain_cycles
);
   import isb_pkg::*;

   localparam int NUM_LEAF = NUM_REGS + NUM_UNITS;
   localparam int LEAVES   = 1 << $clog2(NUM_LEAF);

   // heap ordered max tree, node k has children 2k+1 and 2k+2
   cnt_type node [2*LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < NUM_REGS) begin : g_reg
         assign node[LEAVES-1+j] = reg_busy[j];
      end else if (j < NUM_LEAF) begin : g_unit
         assign node[LEAVES-1+j] = unit_busy[j-NUM_REGS];
      end else begin : g_pad
         assign node[LEAVES-1+j] = '0;
      end
   end

   for (genvar k = 0; k < LEAVES-1; k++) begin : g_node
      assign node[k] = cnt_max(node[2*k+1], node[2*k+2]);
   end

   assign drain_cycles = node[0];

endmodule

[rtl/coprocessor_issue_scoreboard_core.sv]
`timescale 1ns / 1ps

// issue timing scoreboard for a multi-precision coprocessor
//
// req_*: one command word per handshake (opcode, operand registers a and b
//   with their limb counts, result register c). a word is taken at every
//   edge where req_valid and req_ready are both high
// rsp_*: one result word per command, the stall before issue and the drain
//   time (largest busy counter once the command has been booked)
// csr_*: write only port for the eight delay registers, always ready
//
// path: a taken command is held in the command register, then booked into
//   the busy counters; the max tree over all counters gives the drain time,
//   and the result register takes it together with the stall
// throughput: one command per clock when not stalled; the counter update for
//   a command needs the counters left by the one before, a registered loop
// stall: the three stages move together; when rsp_ready is low with a
//   result pending, req_ready drops in the same cycle and nothing moves,
//   the counters included
// reset: all busy counters and delay registers go to zero, pipeline empties

module coprocessor_issue_scoreboard_core #(
   parameter int NUM_REGS   = isb_pkg::NUM_REGS_DEF,
   parameter int CTRL_DELAY = isb_pkg::CTRL_DELAY_DEF,
   parameter int MAX_LIMBS  = isb_pkg::MAX_LIMBS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [isb_pkg::OP_W-1:0]        req_op_code,
   input  logic [isb_pkg::REG_W-1:0]       req_first_reg,
   input  logic [isb_pkg::LIMB_W-1:0]      req_first_limbs,
   input  logic [isb_pkg::REG_W-1:0]       req_second_reg,
   input  logic [isb_pkg::LIMB_W-1:0]      req_second_limbs,
   input  logic [isb_pkg::REG_W-1:0]       req_dest_reg,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [isb_pkg::CNT_W-1:0]       rsp_stall_cycles,
   output logic [isb_pkg::CNT_W-1:0]       rsp_drain_cycles,
   // control register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [isb_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [isb_pkg::CFG_W-1:0]       csr_wdata
);
   import isb_pkg::*;

   // pipeline valids: command register, booked stage, result register
   logic        cmd_valid_ff;
   logic        book_valid_ff;
   logic        rsp_valid_ff;
   isb_cmd_type cmd_ff;
   isb_cfg_type cfg_ff;
   cnt_type     rsp_stall_ff;
   cnt_type     rsp_drain_ff;

   logic        advance;
   cnt_type     book_stall;
   cnt_type     drain_now;
   cnt_type     reg_busy [NUM_REGS];
   cnt_type     unit_busy [NUM_UNITS];

   // everything moves when the result register is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff  <= 1'b0;
         book_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         cmd_valid_ff  <= req_valid;
         book_valid_ff <= cmd_valid_ff;
         rsp_valid_ff  <= book_valid_ff;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff.op_code      <= req_op_code;
         cmd_ff.first_reg    <= req_first_reg;
         cmd_ff.first_limbs  <= req_first_limbs;
         cmd_ff.second_reg   <= req_second_reg;
         cmd_ff.second_limbs <= req_second_limbs;
         cmd_ff.dest_reg     <= req_dest_reg;
         rsp_stall_ff        <= book_stall;
         rsp_drain_ff        <= drain_now;
      end
   end

   // delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CFG_LD_SETUP:  cfg_ff.ld_setup  <= csr_wdata;
            CFG_LD_HOLD:   cfg_ff.ld_hold   <= csr_wdata;
            CFG_UL_SETUP:  cfg_ff.ul_setup  <= csr_wdata;
            CFG_UL_HOLD:   cfg_ff.ul_hold   <= csr_wdata;
            CFG_MUL_SETUP: cfg_ff.mul_setup <= csr_wdata;
            CFG_MUL_DRAIN: cfg_ff.mul_drain <= csr_wdata;
            CFG_AS_SETUP:  cfg_ff.as_setup  <= csr_wdata;
            CFG_AS_DRAIN:  cfg_ff.as_drain  <= csr_wdata;
            default:       cfg_ff           <= cfg_ff;
         endcase
      end
   end

   // busy counters and stall for the command in the command register
   isb_update #(
      .NUM_REGS   (NUM_REGS),
      .CTRL_DELAY (CTRL_DELAY),
      .MAX_LIMBS  (MAX_LIMBS)
   ) u_update (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cmd_valid    (cmd_valid_ff),
      .cmd          (cmd_ff),
      .cfg          (cfg_ff),
      .stall_cycles (book_stall),
      .reg_busy     (reg_busy),
      .unit_busy    (unit_busy)
   );

   // counters hold the booked state of the command in the middle stage
   isb_drain #(
      .NUM_REGS (NUM_REGS)
   ) u_drain (
      .reg_busy     (reg_busy),
      .unit_busy    (unit_busy),
      .drain_cycles (drain_now)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stall_cycles = rsp_stall_ff;
   assign rsp_drain_cycles = rsp_drain_ff;

   // a stall never drops below the control delay
   a_stall_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stall_cycles >= CNT_W'(CTRL_DELAY)))
      else $error("stall below control delay");

   // the block is ready for a command right after reset
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("not ready after reset");

   // an unknown opcode costs only the control delay
   a_noop_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid_ff && advance &&
       !(cmd_ff.op_code == OP_LOAD_A || cmd_ff.op_code == OP_LOAD_B ||
         cmd_ff.op_code == OP_LOAD_AB || cmd_ff.op_code == OP_UNLOAD ||
         cmd_ff.op_code == OP_MULT || cmd_ff.op_code == OP_ADD ||
         cmd_ff.op_code == OP_SUB))
      |=> (book_stall == CNT_W'(CTRL_DELAY)))
      else $error("no-op stall mismatch");

   // a booked command holds its stall while the result side is blocked
   a_book_hold: assert property (@(posedge clock) disable iff (reset)
      (book_valid_ff && !advance) |=> (book_valid_ff && $stable(book_stall)))
      else $error("booked stage moved while blocked");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import isb_pkg::*;

   // block configuration as instantiated (package defaults)
   localparam int REG_COUNT      = NUM_REGS_DEF;
   localparam int CTRL_CYCLES    = CTRL_DELAY_DEF;
   localparam int MAX_LIMB_COUNT = MAX_LIMBS_DEF;

   // run control
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_EDGES = 6;

   // opcodes the block does not decode, used to hit the no-op path
   localparam logic [OP_W-1:0] OP_UNUSED_LOW = 4'd0;
   localparam logic [OP_W-1:0] OP_UNUSED_MID = 4'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_TOP = 4'd15;

   typedef struct {
      cnt_type stall;
      cnt_type drain;
   } issue_timing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_op_code      = '0;
   logic [REG_W-1:0]  req_first_reg    = '0;
   logic [LIMB_W-1:0] req_first_limbs  = '0;
   logic [REG_W-1:0]  req_second_reg   = '0;
   logic [LIMB_W-1:0] req_second_limbs = '0;
   logic [REG_W-1:0]  req_dest_reg     = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CNT_W-1:0]  rsp_stall_cycles;
   logic [CNT_W-1:0]  rsp_drain_cycles;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   coprocessor_issue_scoreboard_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op_code      (req_op_code),
      .req_first_reg    (req_first_reg),
      .req_first_limbs  (req_first_limbs),
      .req_second_reg   (req_second_reg),
      .req_second_limbs (req_second_limbs),
      .req_dest_reg     (req_dest_reg),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stall_cycles (rsp_stall_cycles),
      .rsp_drain_cycles (rsp_drain_cycles),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow scoreboard: delay registers and every busy counter
   // ---------------------------------------------------------------
   isb_cfg_type delay_cfg = '0;
   cnt_type     reg_busy [REG_COUNT];
   cnt_type     unit_busy [NUM_UNITS];

   issue_timing_type   expected_timing [$];
   isb_cmd_type        pending_cmds [$];

   int  mismatch_count  = 0;
   int  csr_writes_seen = 0;
   int  cycle_count     = 0;
   bit  cmd_taken       = 1'b0;
   bit  steady          = 1'b0;   // no gaps and no back-pressure
   int  send_gap        = 0;
   int  sink_hold       = 0;

   initial begin
      foreach (reg_busy[i]) reg_busy[i] = '0;
      foreach (unit_busy[i]) unit_busy[i] = '0;
   end

   function automatic cnt_type add_sat(input longint a, input longint b);
      longint s;
      s = a + b;
      return (s > longint'(CNT_MAX)) ? CNT_MAX : cnt_type'(s);
   endfunction

   function automatic cnt_type sub_floor(input cnt_type x, input cnt_type t);
      if (x <= t) return '0;
      return x - t;
   endfunction

   function automatic cnt_type larger(input cnt_type a, input cnt_type b);
      return (a >= b) ? a : b;
   endfunction

   function automatic cnt_type clip_limbs(input logic [LIMB_W-1:0] v);
      return (v > MAX_LIMB_COUNT) ? cnt_type'(MAX_LIMB_COUNT) : cnt_type'(v);
   endfunction

   // book one command: find the stall, age every counter by it, then add
   // the new busy times; returns the stall and the resulting drain time
   task automatic book_command(input isb_cmd_type c, output issue_timing_type t);
      cnt_type la, lb, n, pre_d, post_d, part, full, hold, route_low, route_add;
      cnt_type reg_add [REG_COUNT];
      bit      reg_hit [REG_COUNT];
      cnt_type unit_add [NUM_UNITS];
      cnt_type stall, drain;

      foreach (reg_add[i]) begin
         reg_add[i] = '0;
         reg_hit[i] = 1'b0;
      end
      foreach (unit_add[i]) unit_add[i] = '0;
      la        = clip_limbs(c.first_limbs);
      lb        = clip_limbs(c.second_limbs);
      hold      = '0;
      route_add = '0;
      route_low = (unit_busy[U_ROUTE0] < unit_busy[U_ROUTE1]) ?
                  unit_busy[U_ROUTE0] : unit_busy[U_ROUTE1];

      case (c.op_code)
         OP_LOAD_A: begin
            part = add_sat(delay_cfg.ld_setup, la);
            hold = larger(reg_busy[c.first_reg], unit_busy[U_PORT_A]);
            reg_add[c.first_reg] = part;
            reg_hit[c.first_reg] = 1'b1;
            unit_add[U_PORT_A]   = part;
         end
         OP_LOAD_B: begin
            part = add_sat(delay_cfg.ld_setup, lb);
            hold = larger(reg_busy[c.second_reg], unit_busy[U_PORT_B]);
            reg_add[c.second_reg] = part;
            reg_hit[c.second_reg] = 1'b1;
            unit_add[U_PORT_B]    = part;
         end
         OP_LOAD_AB: begin
            hold = larger(larger(reg_busy[c.first_reg], reg_busy[c.second_reg]),
                          larger(unit_busy[U_PORT_A], unit_busy[U_PORT_B]));
            // b written after a, so b wins when both name one register
            reg_add[c.first_reg]  = add_sat(add_sat(delay_cfg.ld_setup, la),
                                            delay_cfg.ld_hold);
            reg_hit[c.first_reg]  = 1'b1;
            reg_add[c.second_reg] = add_sat(add_sat(delay_cfg.ld_setup, lb),
                                            delay_cfg.ld_hold);
            reg_hit[c.second_reg] = 1'b1;
            unit_add[U_PORT_A]    = add_sat(delay_cfg.ld_setup, la);
            unit_add[U_PORT_B]    = add_sat(delay_cfg.ld_setup, lb);
         end
         OP_UNLOAD: begin
            part = add_sat(delay_cfg.ul_setup, la);
            hold = larger(larger(unit_busy[U_DMA_UNLOAD], route_low),
                          reg_busy[c.first_reg]);
            unit_add[U_DMA_UNLOAD] = add_sat(part, delay_cfg.ul_hold);
            route_add              = part;
            reg_add[c.first_reg]   = part;
            reg_hit[c.first_reg]   = 1'b1;
         end
         OP_MULT, OP_ADD, OP_SUB: begin
            if (c.op_code == OP_MULT) begin
               n      = la * lb;
               pre_d  = delay_cfg.mul_setup;
               post_d = delay_cfg.mul_drain;
            end else begin
               n      = larger(la, lb);
               pre_d  = delay_cfg.as_setup;
               post_d = delay_cfg.as_drain;
            end
            part = add_sat(pre_d, n);
            full = add_sat(part, post_d);
            hold = larger(reg_busy[c.first_reg],
                          larger(reg_busy[c.second_reg], reg_busy[c.dest_reg]));
            hold = larger(hold, route_low);
            if (c.op_code == OP_MULT) begin
               hold = larger(hold, larger(unit_busy[U_DMA_MULT], unit_busy[U_MULT]));
               unit_add[U_DMA_MULT] = full;
               unit_add[U_MULT]     = full;
            end else begin
               hold = larger(hold, larger(unit_busy[U_DMA_ADDSUB], unit_busy[U_ADDER]));
               unit_add[U_DMA_ADDSUB] = full;
               unit_add[U_ADDER]      = full;
            end
            route_add = full;
            // order a, b, c: the last one naming a register sets it
            reg_add[c.first_reg]  = part;
            reg_hit[c.first_reg]  = 1'b1;
            reg_add[c.second_reg] = part;
            reg_hit[c.second_reg] = 1'b1;
            reg_add[c.dest_reg]   = full;
            reg_hit[c.dest_reg]   = 1'b1;
         end
         default: ;   // no-op: only the control delay
      endcase

      stall = add_sat(CTRL_CYCLES, hold);

      foreach (reg_busy[i]) begin
         reg_busy[i] = sub_floor(reg_busy[i], stall);
         if (reg_hit[i]) reg_busy[i] = add_sat(reg_busy[i], reg_add[i]);
      end
      foreach (unit_busy[i])
         unit_busy[i] = add_sat(sub_floor(unit_busy[i], stall), unit_add[i]);
      // route zero takes the new work when it has drained
      if (unit_busy[U_ROUTE0] == '0)
         unit_busy[U_ROUTE0] = add_sat(unit_busy[U_ROUTE0], route_add);
      else
         unit_busy[U_ROUTE1] = add_sat(unit_busy[U_ROUTE1], route_add);

      drain = '0;
      foreach (reg_busy[i]) drain = larger(drain, reg_busy[i]);
      foreach (unit_busy[i]) drain = larger(drain, unit_busy[i]);

      t.stall = stall;
      t.drain = drain;
   endtask

   task automatic report_mismatch(input string what, input cnt_type got,
                                  input cnt_type want);
      mismatch_count++;
      $display("mismatch %s: got %0d expected %0d (cycle %0d)",
               what, got, want, cycle_count);
   endtask

   // ---------------------------------------------------------------
   // monitor: every handshake sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_side
      isb_cmd_type      seen_cmd;
      issue_timing_type want;

      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL coprocessor_issue_scoreboard_core");
         $finish;
      end else if (!reset) begin
         // a command word goes through the shadow scoreboard on acceptance
         if (req_valid && req_ready) begin
            seen_cmd.op_code      = req_op_code;
            seen_cmd.first_reg    = req_first_reg;
            seen_cmd.first_limbs  = req_first_limbs;
            seen_cmd.second_reg   = req_second_reg;
            seen_cmd.second_limbs = req_second_limbs;
            seen_cmd.dest_reg     = req_dest_reg;
            book_command(seen_cmd, want);
            expected_timing.push_back(want);
            cmd_taken <= 1'b1;
         end else begin
            cmd_taken <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CFG_LD_SETUP:  delay_cfg.ld_setup  = csr_wdata;
               CFG_LD_HOLD:   delay_cfg.ld_hold   = csr_wdata;
               CFG_UL_SETUP:  delay_cfg.ul_setup  = csr_wdata;
               CFG_UL_HOLD:   delay_cfg.ul_hold   = csr_wdata;
               CFG_MUL_SETUP: delay_cfg.mul_setup = csr_wdata;
               CFG_MUL_DRAIN: delay_cfg.mul_drain = csr_wdata;
               CFG_AS_SETUP:  delay_cfg.as_setup  = csr_wdata;
               CFG_AS_DRAIN:  delay_cfg.as_drain  = csr_wdata;
               default: ;
            endcase
            csr_writes_seen <= csr_writes_seen + 1;
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_timing.size() == 0) begin
               report_mismatch("result word with nothing pending",
                               rsp_stall_cycles, '0);
            end else begin
               want = expected_timing.pop_front();
               if (rsp_stall_cycles !== want.stall)
                  report_mismatch("stall_cycles", rsp_stall_cycles, want.stall);
               if (rsp_drain_cycles !== want.drain)
                  report_mismatch("drain_cycles", rsp_drain_cycles, want.drain);
            end
         end
      end
   end

   // mostly short gaps, now and then a long one; none in steady phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // command driver, fed from pending_cmds, changes at the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin : send_side
      isb_cmd_type next_cmd;

      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !cmd_taken) begin
         // word still waiting for ready: hold it
      end else if (send_gap != 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
         next_cmd = pending_cmds.pop_front();
         req_op_code      <= next_cmd.op_code;
         req_first_reg    <= next_cmd.first_reg;
         req_first_limbs  <= next_cmd.first_limbs;
         req_second_reg   <= next_cmd.second_reg;
         req_second_limbs <= next_cmd.second_limbs;
         req_dest_reg     <= next_cmd.dest_reg;
         req_valid        <= 1'b1;
         send_gap         <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result side back-pressure: random stall bursts
   always @(negedge clock) begin
      if (sink_hold != 0) begin
         rsp_ready <= 1'b0;
         sink_hold <= sink_hold - 1;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         sink_hold <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   function automatic bit is_known_op(input logic [OP_W-1:0] op);
      case (op)
         OP_LOAD_A, OP_LOAD_B, OP_LOAD_AB, OP_UNLOAD,
         OP_MULT, OP_ADD, OP_SUB: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic push_cmd(input logic [OP_W-1:0] op, input int ra, input int la,
                           input int rb, input int lb, input int rc);
      isb_cmd_type c;
      c.op_code      = op;
      c.first_reg    = ra[REG_W-1:0];
      c.first_limbs  = la[LIMB_W-1:0];
      c.second_reg   = rb[REG_W-1:0];
      c.second_limbs = lb[LIMB_W-1:0];
      c.dest_reg     = rc[REG_W-1:0];
      pending_cmds.push_back(c);
   endtask

   function automatic int pick_reg();
      // a narrow pool now and then so operands collide and chain
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 2);
      return $urandom_range(0, REG_COUNT - 1);
   endfunction

   function automatic int pick_limbs();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 8);
      if (r < 85) return $urandom_range(9, 64);
      if (r < 95) return $urandom_range(65, MAX_LIMB_COUNT);
      return $urandom_range(MAX_LIMB_COUNT + 1, (1 << LIMB_W) - 1);
   endfunction

   task automatic push_random_cmd();
      logic [OP_W-1:0] op;
      int r;
      r = $urandom_range(0, 99);
      if      (r < 12) op = OP_LOAD_A;
      else if (r < 24) op = OP_LOAD_B;
      else if (r < 36) op = OP_LOAD_AB;
      else if (r < 48) op = OP_UNLOAD;
      else if (r < 64) op = OP_MULT;
      else if (r < 78) op = OP_ADD;
      else if (r < 92) op = OP_SUB;
      else begin
         op = OP_W'($urandom_range(0, 15));
         while (is_known_op(op)) op = OP_W'($urandom_range(0, 15));
      end
      push_cmd(op, pick_reg(), pick_limbs(), pick_reg(), pick_limbs(), pick_reg());
   endtask

   task automatic push_directed_cmds();
      // field extremes, limb clamping, every opcode
      push_cmd(OP_LOAD_A,  0, 0, 0, 0, 0);
      push_cmd(OP_LOAD_A, 15, MAX_LIMB_COUNT, 15, 511, 15);
      push_cmd(OP_LOAD_B, 15, 511, 15, 511, 15);
      push_cmd(OP_LOAD_B,  0, 0, 7, MAX_LIMB_COUNT + 1, 0);
      // dual load into one register: b's time wins
      push_cmd(OP_LOAD_AB, 3, 4, 3, 9, 0);
      push_cmd(OP_LOAD_AB, 1, 20, 2, 2, 0);
      // back to back unloads fill both routes
      push_cmd(OP_UNLOAD, 15, MAX_LIMB_COUNT + 1, 0, 0, 0);
      push_cmd(OP_UNLOAD,  4, 0, 0, 0, 0);
      push_cmd(OP_UNLOAD,  5, 30, 0, 0, 0);
      // largest product
      push_cmd(OP_MULT, 1, MAX_LIMB_COUNT, 2, MAX_LIMB_COUNT, 3);
      push_cmd(OP_MULT, 5, 7, 5, 9, 5);
      push_cmd(OP_MULT, 6, 0, 7, 511, 8);
      push_cmd(OP_ADD, 4, 511, 5, 0, 6);
      push_cmd(OP_ADD, 9, 3, 10, 12, 10);
      push_cmd(OP_SUB, 11, 6, 12, 1, 11);
      push_cmd(OP_SUB, 0, 0, 0, 0, 0);
      push_cmd(OP_ADD, 14, 2, 14, 200, 13);
      // undecoded opcodes, two of them with every field at its top value
      push_cmd(OP_UNUSED_LOW, 15, 511, 15, 511, 15);
      push_cmd(OP_UNUSED_MID, 3, 100, 4, 100, 5);
      push_cmd(OP_UNUSED_TOP, 15, 511, 15, 511, 15);
      push_cmd(OP_SUB, 13, MAX_LIMB_COUNT, 12, MAX_LIMB_COUNT, 15);
      push_cmd(OP_LOAD_A, 13, 5, 0, 0, 0);
   endtask

   // caller sits on a falling edge; returns on the falling edge after the
   // write has been taken
   task automatic write_csr(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] val);
      int seen;
      seen = csr_writes_seen;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (csr_writes_seen == seen);
   endtask

   task automatic program_delays(input isb_cfg_type d);
      write_csr(CFG_LD_SETUP,  d.ld_setup);
      write_csr(CFG_LD_HOLD,   d.ld_hold);
      write_csr(CFG_UL_SETUP,  d.ul_setup);
      write_csr(CFG_UL_HOLD,   d.ul_hold);
      write_csr(CFG_MUL_SETUP, d.mul_setup);
      write_csr(CFG_MUL_DRAIN, d.mul_drain);
      write_csr(CFG_AS_SETUP,  d.as_setup);
      write_csr(CFG_AS_DRAIN,  d.as_drain);
      csr_valid <= 1'b0;
   endtask

   // every queued command sent and every result back, then let the
   // pipeline settle before touching the delay registers
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_timing.size() != 0)
         @(posedge clock);
      repeat (SETTLE_EDGES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input isb_cfg_type d, input int count,
                            input bit no_idle, input bit with_directed);
      program_delays(d);
      steady = no_idle;
      if (with_directed) push_directed_cmds();
      repeat (count) push_random_cmd();
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_phase('{8'd3, 8'd5, 8'd7, 8'd2, 8'd4, 8'd6, 8'd1, 8'd9}, 100, 1'b0, 1'b1);
      run_phase('0, 150, 1'b0, 1'b0);
      run_phase('1, 150, 1'b1, 1'b0);
      run_phase(isb_cfg_type'({$urandom, $urandom}), 175, 1'b0, 1'b0);
      run_phase(isb_cfg_type'({$urandom, $urandom}), 175, 1'b0, 1'b0);

      if (mismatch_count == 0)
         $display("PASS coprocessor_issue_scoreboard_core");
      else
         $display("FAIL coprocessor_issue_scoreboard_core");
      $finish;
   end

endmodule
